// File: rtl/mlia_pkg.sv
// Shared types, constants and helper functions for the multitone lock-in demodulator.
package mlia_pkg;

  localparam int TONE_COUNT_DEF          = 4;
  localparam int QUARTER_TABLE_DEPTH_DEF = 256;
  localparam int MAX_WINDOW_DEF          = 65536;
  localparam int SUM_WIDTH_DEF           = 48;
  localparam int CORDIC_STEPS_DEF        = 24;

  localparam int SAMPLE_W    = 16;
  localparam int STEP_W      = 32;
  localparam int REF_W       = 13;
  localparam int OUT_SUM_W   = 48;
  localparam int AMP_W       = 48;
  localparam int ANGLE_W     = 16;
  localparam int CX_W        = 52;
  localparam int CFG_INDEX_W = 8;
  localparam int REG_COUNT   = 4;

  localparam logic [31:0] INV_GAIN  = 32'd2608131496;
  localparam logic [31:0] Z_HALF    = 32'h8000_0000;
  localparam logic [15:0] QUARTER   = 16'h4000;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;

  localparam logic [STEP_W-1:0] STEP_RESET [REG_COUNT] = '{
    32'd4294967, 32'd42949672, 32'd429496729, 32'd2147483648
  };

  localparam logic [31:0] ATAN_TURN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic load_sample;
    logic clear_phase;
    logic mul;
    logic acc;
    logic cload;
    logic citer;
    logic gain1;
    logic gain2;
    logic clear_count;
  } mlia_cmd_t;

  // floor(a*b/2^60), elaboration use only
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [63:0] al, ah, bl, bh, lo, m1, m2, hi, t, lo64, hi64;
    al = {32'd0, a[31:0]};
    ah = {32'd0, a[63:32]};
    bl = {32'd0, b[31:0]};
    bh = {32'd0, b[63:32]};
    lo = al * bl;
    m1 = ah * bl;
    m2 = al * bh;
    hi = ah * bh;
    t = (lo >> 32) + {32'd0, m1[31:0]} + {32'd0, m2[31:0]};
    lo64 = {t[31:0], lo[31:0]};
    hi64 = hi + (m1 >> 32) + (m2 >> 32) + (t >> 32);
    return (hi64 << 4) | (lo64 >> 60);
  endfunction

endpackage

// File: rtl/mlia_ctrl.sv
// Sequencing state machine for the lock-in demodulator.
module mlia_ctrl
  #(parameter int TONE_COUNT   = mlia_pkg::TONE_COUNT_DEF,
    parameter int CORDIC_STEPS = mlia_pkg::CORDIC_STEPS_DEF,
    parameter int TW = (TONE_COUNT > 1) ? $clog2(TONE_COUNT) : 1,
    parameter int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1)
  (input  logic               clk,
   input  logic               rst,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic               action,
   input  logic               window_end,
   output logic               out_valid,
   input  logic               out_ready,
   output mlia_pkg::mlia_cmd_t cmd,
   output logic [TW-1:0]      tone,
   output logic [IW-1:0]      iter,
   output logic               last);
  import mlia_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_ACC   = 8'b0000_0100,
    S_CLOAD = 8'b0000_1000,
    S_CITER = 8'b0001_0000,
    S_GAIN1 = 8'b0010_0000,
    S_GAIN2 = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   end_flag;
  logic   take;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign take      = in_valid && in_ready;
  assign last      = (tone == TW'(TONE_COUNT - 1));

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (action) begin
            cmd.clear_phase = 1'b1;
          end else begin
            cmd.load_sample = 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (!last) state_next = S_MUL;
        else if (end_flag) state_next = S_CLOAD;
        else state_next = S_IDLE;
      end
      S_CLOAD: begin
        cmd.cload = 1'b1;
        state_next = S_CITER;
      end
      S_CITER: begin
        cmd.citer = 1'b1;
        if (iter == IW'(CORDIC_STEPS - 1)) state_next = S_GAIN1;
      end
      S_GAIN1: begin
        cmd.gain1 = 1'b1;
        state_next = S_GAIN2;
      end
      S_GAIN2: begin
        cmd.gain2 = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (last) begin
            cmd.clear_count = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_CLOAD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tone     <= '0;
      iter     <= '0;
      end_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_sample) begin
        end_flag <= window_end;
        tone     <= '0;
      end
      if (cmd.acc) tone <= last ? '0 : tone + 1'b1;
      if (cmd.cload) iter <= '0;
      if (cmd.citer) iter <= iter + 1'b1;
      if (out_valid && out_ready && !last) tone <= tone + 1'b1;
    end
  end

endmodule

// File: rtl/mlia_dp.sv
// Datapath: phase accumulators, sine table, MAC, CORDIC and gain correction.
module mlia_dp
  #(parameter int TONE_COUNT          = mlia_pkg::TONE_COUNT_DEF,
    parameter int QUARTER_TABLE_DEPTH = mlia_pkg::QUARTER_TABLE_DEPTH_DEF,
    parameter int MAX_WINDOW          = mlia_pkg::MAX_WINDOW_DEF,
    parameter int SUM_WIDTH           = mlia_pkg::SUM_WIDTH_DEF,
    parameter int CORDIC_STEPS        = mlia_pkg::CORDIC_STEPS_DEF,
    parameter int TW = (TONE_COUNT > 1) ? $clog2(TONE_COUNT) : 1,
    parameter int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1,
    parameter int CW = $clog2(MAX_WINDOW + 1))
  (input  logic                                 clk,
   input  logic                                 rst,
   input  logic                                 cfg_write,
   input  logic [mlia_pkg::CFG_INDEX_W-1:0]     cfg_index,
   input  logic [mlia_pkg::STEP_W-1:0]          cfg_data,
   input  logic signed [mlia_pkg::SAMPLE_W-1:0] sample_value,
   input  mlia_pkg::mlia_cmd_t                  cmd,
   input  logic [TW-1:0]                        tone,
   input  logic [IW-1:0]                        iter,
   input  logic                                 last,
   output logic [TW-1:0]                        tone_index,
   output logic signed [mlia_pkg::OUT_SUM_W-1:0] in_phase_sum,
   output logic signed [mlia_pkg::OUT_SUM_W-1:0] quadrature_sum,
   output logic [CW-1:0]                        window_samples,
   output logic [mlia_pkg::AMP_W-1:0]           amplitude,
   output logic signed [mlia_pkg::ANGLE_W-1:0]  angle,
   output logic                                 last_tone);
  import mlia_pkg::*;

  localparam int EW  = $clog2(QUARTER_TABLE_DEPTH);
  localparam int PW  = SAMPLE_W + REF_W + 1;
  localparam int XW  = (SUM_WIDTH > OUT_SUM_W) ? SUM_WIDTH : OUT_SUM_W;
  localparam int REGS = (TONE_COUNT < REG_COUNT) ? TONE_COUNT : REG_COUNT;
  localparam logic signed [XW-1:0] CMAX = XW'({1'b0, {(OUT_SUM_W-1){1'b1}}});
  localparam logic signed [XW-1:0] CMIN = -CMAX - XW'(1);
  localparam logic [63:0] X_STEP  = HALF_PI_Q60 / QUARTER_TABLE_DEPTH;
  localparam logic [63:0] X_REM   = HALF_PI_Q60 % QUARTER_TABLE_DEPTH;
  localparam logic [63:0] DEPTH64 = 64'(QUARTER_TABLE_DEPTH);

  typedef logic [REF_W-1:0] rom_t [QUARTER_TABLE_DEPTH];

  // Divide a series term by (2k)(2k+1), elaboration use only
  function automatic logic [63:0] taylor_div(logic [63:0] t, int k);
    logic [63:0] q;
    unique case (k)
      1:  q = t / 64'd6;
      2:  q = t / 64'd20;
      3:  q = t / 64'd42;
      4:  q = t / 64'd72;
      5:  q = t / 64'd110;
      6:  q = t / 64'd156;
      7:  q = t / 64'd210;
      8:  q = t / 64'd272;
      9:  q = t / 64'd342;
      10: q = t / 64'd420;
      11: q = t / 64'd506;
      12: q = t / 64'd600;
      default: q = t / 64'd702;
    endcase
    return q;
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    logic [63:0] x, x2, term, acc, frac, carry;
    frac = '0;
    carry = '0;
    for (int i = 0; i < QUARTER_TABLE_DEPTH; i++) begin
      x = X_STEP * 64'(i) + carry;
      x2 = mul_q60(x, x);
      term = x;
      acc = x;
      for (int k = 1; k <= 13; k++) begin
        term = taylor_div(mul_q60(term, x2), k);
        if (k[0]) acc = acc - term;
        else acc = acc + term;
      end
      acc = (acc + (64'd1 << 47)) >> 48;
      r[i] = acc[REF_W-1:0];
      // Track floor(X_REM*i/depth) by carrying the remainder
      frac = frac + X_REM;
      if (frac >= DEPTH64) begin
        frac = frac - DEPTH64;
        carry = carry + 64'd1;
      end
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic signed [REF_W:0] sine_ref(logic [15:0] p);
    logic [14+EW-1:0] scaled;
    logic [EW-1:0]    e, m;
    logic signed [REF_W:0] v;
    scaled = (14+EW)'(p[13:0]) * (14+EW)'(QUARTER_TABLE_DEPTH);
    e = scaled[14+EW-1:14];
    m = EW'(QUARTER_TABLE_DEPTH - 1) - e;
    unique case (p[15:14])
      2'd0: v = $signed({1'b0, SINE_ROM[e]});
      2'd1: v = $signed({1'b0, SINE_ROM[m]});
      2'd2: v = -$signed({1'b0, SINE_ROM[e]});
      default: v = -$signed({1'b0, SINE_ROM[m]});
    endcase
    return v;
  endfunction

  function automatic logic signed [SUM_WIDTH-1:0] sat_add(logic signed [SUM_WIDTH-1:0] a,
                                                          logic signed [PW-1:0] b);
    logic signed [SUM_WIDTH:0] s;
    s = {a[SUM_WIDTH-1], a} + (SUM_WIDTH+1)'(b);
    if (s[SUM_WIDTH] != s[SUM_WIDTH-1])
      return s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    return s[SUM_WIDTH-1:0];
  endfunction

  function automatic logic signed [OUT_SUM_W-1:0] clamp(logic signed [SUM_WIDTH-1:0] v);
    logic signed [XW-1:0] w;
    w = XW'(v);
    if (w > CMAX) w = CMAX;
    else if (w < CMIN) w = CMIN;
    return w[OUT_SUM_W-1:0];
  endfunction

  logic [STEP_W-1:0]           step  [TONE_COUNT];
  logic [STEP_W-1:0]           phase [TONE_COUNT];
  logic signed [SUM_WIDTH-1:0] cacc  [TONE_COUNT];
  logic signed [SUM_WIDTH-1:0] sacc  [TONE_COUNT];
  logic [CW-1:0]               count;
  logic signed [SAMPLE_W-1:0]  sample;
  logic signed [PW-1:0]        prod_c, prod_s;
  logic signed [CX_W-1:0]      cx, cy, xs, ys;
  logic [31:0]                 cz;
  logic                        zero;
  logic [CX_W-1:0]             ghi;
  logic [63:0]                 glo;
  logic [15:0]                 p16;
  logic signed [OUT_SUM_W-1:0] iv, qv;
  logic [CX_W:0]               amp_raw;
  logic [31:0]                 z_round;

  assign p16 = phase[tone][STEP_W-1:STEP_W-16];
  assign iv  = clamp(cacc[tone]);
  assign qv  = clamp(sacc[tone]);
  assign xs  = cx >>> iter;
  assign ys  = cy >>> iter;
  assign amp_raw = {1'b0, ghi} + (CX_W+1)'((glo + 64'h8000_0000) >> 32);
  assign z_round = cz + 32'h8000;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TONE_COUNT; k++) begin
        step[k]  <= (k < REG_COUNT) ? STEP_RESET[k] : '0;
        phase[k] <= '0;
        cacc[k]  <= '0;
        sacc[k]  <= '0;
      end
      count <= '0;
    end else begin
      if (cfg_write && cfg_index < CFG_INDEX_W'(REGS)) step[TW'(cfg_index)] <= cfg_data;
      if (cmd.clear_phase) begin
        for (int k = 0; k < TONE_COUNT; k++) phase[k] <= '0;
      end
      if (cmd.load_sample && count < CW'(MAX_WINDOW)) count <= count + 1'b1;
      if (cmd.acc) begin
        cacc[tone]  <= sat_add(cacc[tone], prod_c);
        sacc[tone]  <= sat_add(sacc[tone], prod_s);
        phase[tone] <= phase[tone] + step[tone];
      end
      if (cmd.cload) begin
        cacc[tone] <= '0;
        sacc[tone] <= '0;
      end
      if (cmd.clear_count) count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) sample <= sample_value;
    if (cmd.mul) begin
      prod_c <= PW'(sample * sine_ref(p16 + QUARTER));
      prod_s <= PW'(sample * sine_ref(p16));
    end
    if (cmd.cload) begin
      in_phase_sum   <= iv;
      quadrature_sum <= qv;
      zero <= (iv == '0) && (qv == '0);
      if (iv < 0) begin
        cx <= -CX_W'(iv);
        cy <= -CX_W'(qv);
        cz <= Z_HALF;
      end else begin
        cx <= CX_W'(iv);
        cy <= CX_W'(qv);
        cz <= '0;
      end
    end
    if (cmd.citer) begin
      if (!cy[CX_W-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + ATAN_TURN[iter];
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - ATAN_TURN[iter];
      end
    end
    if (cmd.gain1) begin
      ghi <= CX_W'(cx[CX_W-1:32] * INV_GAIN);
      glo <= {32'd0, cx[31:0]} * {32'd0, INV_GAIN};
    end
    if (cmd.gain2) begin
      tone_index     <= tone;
      last_tone      <= last;
      window_samples <= count;
      if (zero) begin
        amplitude <= '0;
        angle     <= '0;
      end else begin
        amplitude <= (amp_raw[CX_W:AMP_W] != '0) ? {AMP_W{1'b1}} : amp_raw[AMP_W-1:0];
        angle     <= $signed(z_round[31:16]);
      end
    end
  end

endmodule

// File: rtl/multitone_lockin_demodulator.sv
// Top level of the multitone lock-in demodulator.
// Multitone lock-in demodulator. Each accepted sample (action low) is mixed
// with a cosine and a sine reference for every tone and added to that tone's
// saturating I and Q sums; the references come from a 32-bit phase
// accumulator per tone and a quarter-wave sine table. An item with action
// high zeroes all phase accumulators and gives no result. A sample with
// window_end high closes the window: for each tone in turn the block
// transfers the clamped sums, the sample count, a gain-corrected CORDIC
// magnitude and an atan2 angle (pi/32768 units), with last_tone on the final
// one; sums and count then restart, the phases run on. One shared multiplier
// pair serves each tone by a multiply then an accumulate state. Per tone, a
// closing sample loads the CORDIC, runs CORDIC_STEPS rotations at one per
// cycle, corrects the gain in two steps and waits out any output stall.
// Phase steps are written on the configuration port, always ready; the user
// must write them only while idle, which the block itself does not enforce.
module multitone_lockin_demodulator
  #(parameter int TONE_COUNT          = mlia_pkg::TONE_COUNT_DEF,
    parameter int QUARTER_TABLE_DEPTH = mlia_pkg::QUARTER_TABLE_DEPTH_DEF,
    parameter int MAX_WINDOW          = mlia_pkg::MAX_WINDOW_DEF,
    parameter int SUM_WIDTH           = mlia_pkg::SUM_WIDTH_DEF,
    parameter int CORDIC_STEPS        = mlia_pkg::CORDIC_STEPS_DEF,
    parameter int TW = (TONE_COUNT > 1) ? $clog2(TONE_COUNT) : 1,
    parameter int CW = $clog2(MAX_WINDOW + 1))
  (input  logic                                  clk,
   input  logic                                  rst,
   input  logic                                  cfg_valid,
   output logic                                  cfg_ready,
   input  logic [mlia_pkg::CFG_INDEX_W-1:0]      cfg_index,
   input  logic [mlia_pkg::STEP_W-1:0]           cfg_data,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic                                  action,
   input  logic signed [mlia_pkg::SAMPLE_W-1:0]  sample_value,
   input  logic                                  window_end,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [TW-1:0]                         tone_index,
   output logic signed [mlia_pkg::OUT_SUM_W-1:0] in_phase_sum,
   output logic signed [mlia_pkg::OUT_SUM_W-1:0] quadrature_sum,
   output logic [CW-1:0]                         window_samples,
   output logic [mlia_pkg::AMP_W-1:0]            amplitude,
   output logic signed [mlia_pkg::ANGLE_W-1:0]   angle,
   output logic                                  last_tone);
  import mlia_pkg::*;

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  mlia_cmd_t      cmd;
  logic [TW-1:0]  tone;
  logic [IW-1:0]  iter;
  logic           last;

  // Registers are always writable; write only while idle, which is not enforced.
  assign cfg_ready = 1'b1;

  mlia_ctrl #(.TONE_COUNT(TONE_COUNT), .CORDIC_STEPS(CORDIC_STEPS), .TW(TW), .IW(IW))
    u_ctrl (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (in_valid),
      .in_ready   (in_ready),
      .action     (action),
      .window_end (window_end),
      .out_valid  (out_valid),
      .out_ready  (out_ready),
      .cmd        (cmd),
      .tone       (tone),
      .iter       (iter),
      .last       (last));

  mlia_dp #(.TONE_COUNT(TONE_COUNT), .QUARTER_TABLE_DEPTH(QUARTER_TABLE_DEPTH),
            .MAX_WINDOW(MAX_WINDOW), .SUM_WIDTH(SUM_WIDTH),
            .CORDIC_STEPS(CORDIC_STEPS), .TW(TW), .IW(IW), .CW(CW))
    u_dp (
      .clk            (clk),
      .rst            (rst),
      .cfg_write      (cfg_valid && cfg_ready),
      .cfg_index      (cfg_index),
      .cfg_data       (cfg_data),
      .sample_value   (sample_value),
      .cmd            (cmd),
      .tone           (tone),
      .iter           (iter),
      .last           (last),
      .tone_index     (tone_index),
      .in_phase_sum   (in_phase_sum),
      .quadrature_sum (quadrature_sum),
      .window_samples (window_samples),
      .amplitude      (amplitude),
      .angle          (angle),
      .last_tone      (last_tone));

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the multitone lock-in demodulator.
`timescale 1ns / 100ps

module testbench;
  import mlia_pkg::*;

  typedef enum logic { ACT_SAMPLE = 1'b0, ACT_CLEAR = 1'b1 } action_t;

  localparam logic [CFG_INDEX_W-1:0] REG_TONE0_STEP = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE1_STEP = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE2_STEP = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE3_STEP = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED     = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP        = 8'd255;
  localparam int   TONES      = 4;
  localparam int   WINDOW_CAP = 65536;
  // A closing sample costs four tones of CORDIC and gain cycles plus the mixing
  localparam int   SETTLE_CYCLES = 200;
  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -64'sd140737488355328;
  localparam logic [63:0] AMP_MASK = 64'hFFFF_FFFF_FFFF;

  // Arctangent of 2^-i in turns scaled by 2^32
  localparam logic [31:0] ARCTAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct {
    logic [1:0]         tone;
    logic signed [47:0] i_sum;
    logic signed [47:0] q_sum;
    logic [16:0]        count;
    logic [47:0]        amp;
    logic signed [15:0] ang;
    logic               last;
  } tone_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic signed [15:0] sample_value = '0;
  logic window_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] tone_index;
  logic signed [47:0] in_phase_sum;
  logic signed [47:0] quadrature_sum;
  logic [16:0] window_samples;
  logic [47:0] amplitude;
  logic signed [15:0] angle;
  logic last_tone;

  multitone_lockin_demodulator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .sample_value(sample_value), .window_end(window_end),
    .out_valid(out_valid), .out_ready(out_ready), .tone_index(tone_index),
    .in_phase_sum(in_phase_sum), .quadrature_sum(quadrature_sum),
    .window_samples(window_samples), .amplitude(amplitude), .angle(angle),
    .last_tone(last_tone));

  always #5 clk = ~clk;

  // Mirror of the block's state
  int            quarter_sine [256];
  logic [31:0]   phase_step [TONES];
  logic [31:0]   tone_phase [TONES];
  longint        cos_sum [TONES];
  longint        sin_sum [TONES];
  int            window_count;
  tone_result_t  pending_results [$];

  int  mismatches = 0;
  bit  steady = 1'b0;     // suppress random idling on both sides
  int  hold_off = 0;      // receiver stall length requested by a test

  // Signed reference for a 16-bit phase, built from the quarter-wave table
  function automatic longint sine_at(logic [15:0] p);
    logic [7:0] e;
    e = p[13:6];
    case (p[15:14])
      2'd0: return quarter_sine[e];
      2'd1: return quarter_sine[255 - e];
      2'd2: return -quarter_sine[e];
      default: return -quarter_sine[255 - e];
    endcase
  endfunction

  function automatic longint clamp_sum(longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // Vectoring CORDIC: gain-corrected magnitude and angle in pi/32768 units
  function automatic void vector_polar(input longint i_in, input longint q_in,
                                       output logic [47:0] amp,
                                       output logic [15:0] ang);
    longint x, y, xs, ys;
    logic [31:0] z;
    logic [63:0] ux, r;
    x = i_in;
    y = q_in;
    z = '0;
    if (i_in == 0 && q_in == 0) begin
      amp = '0;
      ang = '0;
      return;
    end
    // Turn a left-half vector by pi first
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ARCTAN_STEP[i];
      end else begin
        x -= ys; y += xs; z -= ARCTAN_STEP[i];
      end
    end
    ux = x;
    r = (ux >> 32) * 64'd2608131496
        + (((ux & 64'hFFFF_FFFF) * 64'd2608131496 + 64'h8000_0000) >> 32);
    amp = (r > AMP_MASK) ? AMP_MASK[47:0] : r[47:0];
    z = z + 32'h8000;
    ang = z[31:16];
  endfunction

  // Advance the mirror by one accepted item and queue any window results
  function automatic void mix_sample(logic act, logic signed [15:0] s, logic we);
    logic [15:0] p16;
    tone_result_t r;
    logic [47:0] amp;
    logic [15:0] ang;
    if (act == ACT_CLEAR) begin
      foreach (tone_phase[k]) tone_phase[k] = '0;
      return;
    end
    for (int k = 0; k < TONES; k++) begin
      p16 = tone_phase[k][31:16];
      cos_sum[k] = clamp_sum(cos_sum[k] + longint'(s) * sine_at(p16 + 16'h4000));
      sin_sum[k] = clamp_sum(sin_sum[k] + longint'(s) * sine_at(p16));
      tone_phase[k] += phase_step[k];
    end
    if (window_count < WINDOW_CAP) window_count++;
    if (!we) return;
    for (int k = 0; k < TONES; k++) begin
      vector_polar(cos_sum[k], sin_sum[k], amp, ang);
      r.tone  = k[1:0];
      r.i_sum = cos_sum[k][47:0];
      r.q_sum = sin_sum[k][47:0];
      r.count = window_count[16:0];
      r.amp   = amp;
      r.ang   = ang;
      r.last  = (k == TONES - 1);
      pending_results.push_back(r);
      cos_sum[k] = 0;
      sin_sum[k] = 0;
    end
    window_count = 0;
  endfunction

  task automatic report(string what, longint got, longint want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Receiver: random stalls, long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 7);
    end
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    tone_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (tone_index !== e.tone) report("tone_index", tone_index, e.tone);
        if (in_phase_sum !== e.i_sum) report("in_phase_sum", in_phase_sum, e.i_sum);
        if (quadrature_sum !== e.q_sum) report("quadrature_sum", quadrature_sum, e.q_sum);
        if (window_samples !== e.count) report("window_samples", window_samples, e.count);
        if (amplitude !== e.amp) report("amplitude", amplitude, e.amp);
        if (angle !== e.ang) report("angle", angle, e.ang);
        if (last_tone !== e.last) report("last_tone", last_tone, e.last);
      end
    end
  end

  // Offer one item, idling now and then, and hold it until the transfer
  task automatic send_item(action_t act, logic signed [15:0] s, logic we);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    sample_value <= s;
    window_end   <= we;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mix_sample(act, s, we);
  endtask

  // Drop valid and wait until the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then drop valid for a cycle
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < TONES) phase_step[idx] = val;
    @(posedge clk);
  endtask

  task automatic write_steps(logic [31:0] s0, logic [31:0] s1,
                             logic [31:0] s2, logic [31:0] s3);
    drain();
    write_reg(REG_TONE0_STEP, s0);
    write_reg(REG_TONE1_STEP, s1);
    write_reg(REG_TONE2_STEP, s2);
    write_reg(REG_TONE3_STEP, s3);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed: reset steps, extremes, zero window, left-half vectors, clears
  task automatic test_directed();
    send_item(ACT_SAMPLE, 16'sh7FFF, 1'b1);
    send_item(ACT_SAMPLE, 16'sh8000, 1'b1);
    send_item(ACT_SAMPLE, 16'sh0000, 1'b1);     // both sums zero
    send_item(ACT_SAMPLE, -16'sd1, 1'b0);
    send_item(ACT_SAMPLE, 16'sh8000, 1'b0);
    send_item(ACT_SAMPLE, 16'sh8000, 1'b1);     // negative I
    send_item(ACT_CLEAR, 16'sh7FFF, 1'b1);      // ignored fields, no result
    send_item(ACT_SAMPLE, 16'sd1, 1'b0);
    send_item(ACT_SAMPLE, 16'sh5555, 1'b0);
    send_item(ACT_CLEAR, 16'sh0000, 1'b0);
    send_item(ACT_SAMPLE, 16'shAAAA, 1'b1);     // sums kept over a clear
    for (int n = 0; n < 6; n++) send_item(ACT_SAMPLE, 16'sh7FFF, n == 5);
  endtask

  // Register extremes and out-of-range indexes
  task automatic test_registers();
    write_steps(32'h0000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0001_0000);
    write_reg(REG_UNUSED, 32'h1234_5678);
    write_reg(REG_TOP, 32'hFFFF_FFFF);
    for (int n = 0; n < 8; n++) send_item(ACT_SAMPLE, pick_sample(), n % 4 == 3);
    write_steps(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFF);
    for (int n = 0; n < 8; n++) send_item(ACT_SAMPLE, pick_sample(), n % 4 == 3);
  endtask

  // Random windows over several step settings, with a few clears and noise
  task automatic test_random(int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(4) == 0)
        write_steps($urandom, $urandom, $urandom, $urandom);
      len = $urandom_range(1, 8);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(19) == 0)
          send_item(ACT_CLEAR, 16'($urandom), 1'($urandom_range(1)));
        else
          send_item(ACT_SAMPLE, pick_sample(), n == len - 1);
        sent++;
      end
    end
  endtask

  // Long receiver hold-off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    drain();
    hold_off = 600;
    for (int n = 0; n < 16; n++) send_item(ACT_SAMPLE, 16'($urandom), n % 2 == 1);
    drain();
  endtask

  initial begin
    for (int i = 0; i < 256; i++)
      quarter_sine[i] = $rtoi(4096.0 * $sin(3.14159265358979323846 * i / 512.0) + 0.5);
    phase_step[0] = 32'd4294967;
    phase_step[1] = 32'd42949672;
    phase_step[2] = 32'd429496729;
    phase_step[3] = 32'd2147483648;
    foreach (tone_phase[k]) begin
      tone_phase[k] = '0;
      cos_sum[k] = 0;
      sin_sum[k] = 0;
    end
    window_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_registers();
    test_random(80);
    test_backpressure();
    steady = 1'b1;
    test_random(25);
    steady = 1'b0;
    write_steps(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    test_random(25);

    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard limit well above the slowest correct run
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/mlia_pkg.sv
rtl/mlia_ctrl.sv
rtl/mlia_dp.sv
rtl/multitone_lockin_demodulator.sv
sim/testbench.sv
